### sv/indexed_priority_heap_top_macros.svh
// Assertion macros for the indexed priority heap.
// Used by indexed_priority_heap_top.sv; depends on nothing else.
`ifndef INDEXED_PRIORITY_HEAP_TOP_MACROS_SVH
`define INDEXED_PRIORITY_HEAP_TOP_MACROS_SVH

// Assert that a condition implies a consequence at the same edge.
`define IPH_ASSERT_IMP(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Assert that a condition implies a consequence at the next edge.
`define IPH_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/iph_pkg.sv
// Package for the indexed priority heap: status codes, command codes, types.
// Depends on nothing.
`default_nettype none
package iph_pkg;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_RAISED   = 3'd1;
    localparam logic [2:0] ST_IGNORED  = 3'd2;
    localparam logic [2:0] ST_POPPED   = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CHK,
        S_UP_RD,
        S_UP_RD2,
        S_UP_CMP,
        S_POP_RD,
        S_POP_MOVE,
        S_DN_RD,
        S_DN_RD2,
        S_DN_CMP,
        S_DONE
    } eng_state_t;

endpackage
`default_nettype wire

### sv/indexed_priority_heap_top.sv
// Indexed max-heap over KEY_COUNT keys with push/raise and pop. An item
// enters a two-entry queue and is then carried out by a single heap engine,
// one item at a time. After reset the key-present table is cleared by a pass
// over all KEY_COUNT keys during which no item is started. A push or a pop
// moves its key up or down the heap level by level in a sift loop over the
// heap memories. The result register frees the engine only once its result
// is popped.
`default_nettype none
`include "indexed_priority_heap_top_macros.svh"
module indexed_priority_heap_top
    import iph_pkg::*;
#(
    parameter int KEY_COUNT     = 1024,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic        command,
    input  wire logic [9:0]  key,
    input  wire logic [PRIORITY_BITS-1:0] included,
    input  wire logic [PRIORITY_BITS-1:0] excluded,
    output logic             empty,
    input  wire logic        pop,
    output logic [9:0]       popped_key,
    output logic [2:0]       status,
    output logic             is_empty,
    output logic [10:0]      entry_count
);

    localparam int FW = 1 + 10 + 2 * PRIORITY_BITS;

    logic [FW-1:0] q_data;
    logic          q_empty, take;
    logic          res_valid;

    // Front queue of accepted items.
    iph_cmd_fifo #(.WIDTH(FW)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_en(push), .wr_data({command, key, included, excluded}), .full(full),
        .rd_en(take), .rd_data(q_data), .empty(q_empty)
    );

    // Heap engine.
    iph_engine #(.KEY_COUNT(KEY_COUNT), .PRIORITY_BITS(PRIORITY_BITS),
                 .KW(10), .CW(11)) u_eng (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(!q_empty),
        .cmd_op(q_data[FW-1]),
        .cmd_key(q_data[FW-2 -: 10]),
        .cmd_inc(q_data[2*PRIORITY_BITS-1 -: PRIORITY_BITS]),
        .cmd_exc(q_data[PRIORITY_BITS-1:0]),
        .cmd_take(take),
        .res_valid(res_valid), .res_ready(pop),
        .res_key(popped_key), .res_status(status), .res_count(entry_count)
    );

    assign empty    = !res_valid;
    assign is_empty = (entry_count == 11'd0);

    `IPH_ASSERT_IMP(a_take_has_item, take, !q_empty)
    `IPH_ASSERT_NEXT(a_pop_clears, pop && !empty, empty)
    `IPH_ASSERT_IMP(a_count_range, 1'b1, entry_count <= 11'(KEY_COUNT))

endmodule
`default_nettype wire

### sv/iph_cmd_fifo.sv
// Short queue of accepted items between the front and the heap engine.
// Depends on nothing.
`default_nettype none
module iph_cmd_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    // Two entries, one write and one read pointer bit plus wrap bit.
    logic [WIDTH-1:0] mem_reg [2];
    logic [1:0] wp_reg, rp_reg;

    assign empty   = (wp_reg == rp_reg);
    assign full    = (wp_reg[0] == rp_reg[0]) && (wp_reg[1] != rp_reg[1]);
    assign rd_data = mem_reg[rp_reg[0]];

    // Pointer update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (wr_en && !full)
                wp_reg <= wp_reg + 2'd1;
            if (rd_en && !empty)
                rp_reg <= rp_reg + 2'd1;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
            mem_reg[wp_reg[0]] <= wr_data;
    end

endmodule
`default_nettype wire

### sv/iph_engine.sv
// Heap engine: runs one push or pop against the heap memories.
// Depends on iph_pkg.
`default_nettype none
module iph_engine
    import iph_pkg::*;
#(
    parameter int KEY_COUNT     = 1024,
    parameter int PRIORITY_BITS = 16,
    parameter int KW            = 10,
    parameter int CW            = 11
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cmd_valid,
    input  wire logic                     cmd_op,
    input  wire logic [KW-1:0]            cmd_key,
    input  wire logic [PRIORITY_BITS-1:0] cmd_inc,
    input  wire logic [PRIORITY_BITS-1:0] cmd_exc,
    output logic                          cmd_take,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output logic [KW-1:0]                 res_key,
    output logic [2:0]                    res_status,
    output logic [CW-1:0]                 res_count
);

    localparam int SW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int PW = PRIORITY_BITS;

    // Memories: slot -> key, key -> slot, key -> priority pair.
    logic [KW-1:0] heap_mem [KEY_COUNT];
    logic [SW-1:0] pos_mem  [KEY_COUNT];
    logic [PW-1:0] inc_mem  [KEY_COUNT];
    logic [PW-1:0] exc_mem  [KEY_COUNT];
    logic          present_mem [KEY_COUNT];

    eng_state_t state_reg, state_next;
    logic [CW-1:0] len_reg;
    logic          clr_reg;
    logic [SW-1:0] clr_idx_reg;

    // Working registers.
    logic          op_reg;
    logic [KW-1:0] key_reg;
    logic [PW-1:0] inc_reg, exc_reg;
    logic [SW-1:0] i_reg;          // current slot of the moving key
    logic [SW-1:0] c_reg;          // child or parent slot
    logic [KW-1:0] ck_reg, ck2_reg;
    logic [PW-1:0] ci_reg, ce_reg, ci2_reg, ce2_reg;
    logic          two_reg;
    logic          pres_reg;
    logic          key_in_range_reg;
    logic [PW-1:0] oi_reg, oe_reg;
    logic [KW-1:0] out_key_reg;
    logic [2:0]    out_st_reg;
    logic          out_v_reg;

    function automatic logic beats(input logic [PW-1:0] ai, input logic [PW-1:0] ae,
                                   input logic [PW-1:0] bi, input logic [PW-1:0] be);
        beats = (ai > bi) || ((ai == bi) && (ae <= be));
    endfunction

    logic [CW-1:0] lenm1;
    logic [CW:0]   c1_full;
    logic [CW:0]   c2_full;
    logic          key_in_range;
    logic [SW-1:0] par_idx;
    logic          up_stop, dn_pick2, dn_stop;

    assign lenm1        = len_reg - CW'(1);
    assign c1_full      = {1'b0, i_reg, 1'b1} ;
    assign c2_full      = c1_full + (CW+1)'(1);
    assign key_in_range = (32'(cmd_key) < 32'(KEY_COUNT));
    assign par_idx      = SW'((i_reg - SW'(1)) >> 1);
    assign up_stop      = beats(ci_reg, ce_reg, inc_reg, exc_reg);
    assign dn_pick2     = two_reg && beats(ci2_reg, ce2_reg, ci_reg, ce_reg);
    assign dn_stop      = dn_pick2 ? beats(inc_reg, exc_reg, ci2_reg, ce2_reg)
                                   : beats(inc_reg, exc_reg, ci_reg, ce_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (!clr_reg && cmd_valid && !out_v_reg)
                    state_next = (cmd_op == CMD_POP) ? S_POP_RD : S_PUSH_RD;
            S_PUSH_RD:  state_next = S_PUSH_CHK;
            S_PUSH_CHK: state_next = S_UP_RD;
            S_UP_RD:    state_next = (i_reg == '0) ? S_DONE : S_UP_RD2;
            S_UP_RD2:   state_next = S_UP_CMP;
            S_UP_CMP:   state_next = up_stop ? S_DONE : S_UP_RD;
            S_POP_RD:   state_next = (len_reg == '0) ? S_DONE : S_POP_MOVE;
            S_POP_MOVE: state_next = S_DN_RD;
            S_DN_RD:    state_next = (c1_full < (CW+1)'(len_reg)) ? S_DN_RD2 : S_DONE;
            S_DN_RD2:   state_next = S_DN_CMP;
            S_DN_CMP:   state_next = dn_stop ? S_DONE : S_DN_RD;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Outputs toward the queues.
    always_comb
    begin
        cmd_take = (state_reg == S_IDLE) && !clr_reg && cmd_valid && !out_v_reg;
    end

    assign res_valid  = out_v_reg;
    assign res_key    = out_key_reg;
    assign res_status = out_st_reg;
    assign res_count  = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_reg)
            begin
                clr_idx_reg <= clr_idx_reg + SW'(1);
                if (32'(clr_idx_reg) == KEY_COUNT - 1)
                    clr_reg <= 1'b0;
            end
            if (out_v_reg && res_ready)
                out_v_reg <= 1'b0;
            if (state_reg == S_DONE)
                out_v_reg <= 1'b1;
            if (state_reg == S_PUSH_CHK && key_in_range_reg && !pres_reg)
                len_reg <= len_reg + CW'(1);
            if (state_reg == S_POP_RD && len_reg != '0)
                len_reg <= lenm1;
        end
    end

    // Datapath and memory accesses.
    always_ff @(posedge clk)
    begin
        if (clr_reg)
            present_mem[clr_idx_reg] <= 1'b0;
        unique case (state_reg)
            S_IDLE:
                // Capture a new item only when it is taken, so a waiting result holds.
                if (cmd_take)
                begin
                    op_reg  <= cmd_op;
                    key_reg <= cmd_key;
                    inc_reg <= cmd_inc;
                    exc_reg <= cmd_exc;
                    key_in_range_reg <= key_in_range;
                    out_key_reg <= '0;
                end
            S_PUSH_RD:
            begin
                pres_reg <= present_mem[SW'(key_reg)];
                oi_reg   <= inc_mem[SW'(key_reg)];
                oe_reg   <= exc_mem[SW'(key_reg)];
                i_reg    <= pos_mem[SW'(key_reg)];
            end
            S_PUSH_CHK:
            begin
                if (!key_in_range_reg)
                begin
                    out_st_reg <= ST_IGNORED;
                    i_reg      <= '0;
                end
                else if (!pres_reg)
                begin
                    present_mem[SW'(key_reg)] <= 1'b1;
                    inc_mem[SW'(key_reg)]     <= inc_reg;
                    exc_mem[SW'(key_reg)]     <= exc_reg;
                    heap_mem[SW'(len_reg)]    <= key_reg;
                    pos_mem[SW'(key_reg)]     <= SW'(len_reg);
                    i_reg      <= SW'(len_reg);
                    out_st_reg <= ST_INSERTED;
                end
                else if (beats(oi_reg, oe_reg, inc_reg, exc_reg))
                begin
                    out_st_reg <= ST_IGNORED;
                    i_reg      <= '0;
                end
                else
                begin
                    inc_mem[SW'(key_reg)] <= inc_reg;
                    exc_mem[SW'(key_reg)] <= exc_reg;
                    out_st_reg <= ST_RAISED;
                end
            end
            S_UP_RD:
            begin
                c_reg  <= par_idx;
                ck_reg <= heap_mem[par_idx];
            end
            // Parent priority is read from the registered parent key.
            S_UP_RD2:
            begin
                ci_reg <= inc_mem[SW'(ck_reg)];
                ce_reg <= exc_mem[SW'(ck_reg)];
            end
            S_UP_CMP:
                if (!up_stop)
                begin
                    heap_mem[i_reg] <= ck_reg;
                    pos_mem[SW'(ck_reg)] <= i_reg;
                    heap_mem[c_reg] <= key_reg;
                    pos_mem[SW'(key_reg)] <= c_reg;
                    i_reg <= c_reg;
                end
            S_POP_RD:
            begin
                if (len_reg == '0)
                    out_st_reg <= ST_EMPTY;
                else
                begin
                    out_st_reg  <= ST_POPPED;
                    out_key_reg <= heap_mem[0];
                    key_reg <= heap_mem[SW'(lenm1)];
                end
                i_reg <= '0;
            end
            S_POP_MOVE:
            begin
                present_mem[SW'(out_key_reg)] <= 1'b0;
                heap_mem[0] <= key_reg;
                pos_mem[SW'(key_reg)] <= '0;
                inc_reg <= inc_mem[SW'(key_reg)];
                exc_reg <= exc_mem[SW'(key_reg)];
            end
            S_DN_RD:
            begin
                c_reg   <= SW'(c1_full);
                ck_reg  <= heap_mem[SW'(c1_full)];
                ck2_reg <= heap_mem[SW'(c2_full)];
                two_reg <= (c2_full < (CW+1)'(len_reg));
            end
            S_DN_RD2:
            begin
                ci_reg  <= inc_mem[SW'(ck_reg)];
                ce_reg  <= exc_mem[SW'(ck_reg)];
                ci2_reg <= inc_mem[SW'(ck2_reg)];
                ce2_reg <= exc_mem[SW'(ck2_reg)];
            end
            S_DN_CMP:
                if (!dn_stop)
                begin
                    heap_mem[i_reg] <= dn_pick2 ? ck2_reg : ck_reg;
                    pos_mem[dn_pick2 ? SW'(ck2_reg) : SW'(ck_reg)] <= i_reg;
                    heap_mem[dn_pick2 ? c_reg + SW'(1) : c_reg] <= key_reg;
                    pos_mem[SW'(key_reg)] <= dn_pick2 ? c_reg + SW'(1) : c_reg;
                    i_reg <= dn_pick2 ? c_reg + SW'(1) : c_reg;
                end
            default:
            begin
            end
        endcase
    end

    logic unused_op;
    assign unused_op = op_reg;

endmodule
`default_nettype wire

### verif/heap_checker.sv
// Checker for the indexed priority heap: keeps its own copy of the heap,
// predicts one result per accepted item and compares accepted results.
// Depends on iph_pkg for status and command codes.
module heap_checker
    import iph_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic        command,
    input  wire logic [9:0]  key,
    input  wire logic [15:0] included,
    input  wire logic [15:0] excluded,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [9:0]  popped_key,
    input  wire logic [2:0]  status,
    input  wire logic        is_empty,
    input  wire logic [10:0] entry_count,
    output int               fail_count,
    output int               outstanding,
    output int               checked_count,
    output int               pops_seen,
    output int               raises_seen
);

    typedef struct packed {
        logic [9:0]  popped_key;
        logic [2:0]  status;
        logic        is_empty;
        logic [10:0] entry_count;
    } heap_result_t;

    // Shadow heap: keys in heap order, slot of each key, priority of each key.
    logic [9:0]  heap_key [1024];
    logic [10:0] key_slot [1024];
    bit          key_in_heap [1024];
    logic [15:0] key_incl [1024];
    logic [15:0] key_excl [1024];
    int unsigned heap_size;
    heap_result_t pending_results[$];

    // True when pair a outranks or ties pair b.
    function automatic bit outranks(logic [15:0] ai, logic [15:0] ae,
                                    logic [15:0] bi, logic [15:0] be);
        return (ai > bi) || (ai == bi && ae <= be);
    endfunction

    function automatic bit slot_outranks(int unsigned sa, int unsigned sb);
        return outranks(key_incl[heap_key[sa]], key_excl[heap_key[sa]],
                        key_incl[heap_key[sb]], key_excl[heap_key[sb]]);
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [9:0] ka;
        logic [9:0] kb;
        ka = heap_key[a];
        kb = heap_key[b];
        heap_key[a] = kb;
        heap_key[b] = ka;
        key_slot[ka] = 11'(b);
        key_slot[kb] = 11'(a);
    endfunction

    function automatic void climb(logic [9:0] k);
        int unsigned i;
        int unsigned p;
        i = key_slot[k];
        while (i > 0) begin
            p = (i - 1) / 2;
            if (outranks(key_incl[heap_key[p]], key_excl[heap_key[p]],
                         key_incl[k], key_excl[k]))
                break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void descend();
        int unsigned i;
        int unsigned c;
        i = 0;
        while (i < heap_size / 2) begin
            c = 2 * i + 1;
            if (c + 1 < heap_size && slot_outranks(c + 1, c))
                c = c + 1;
            if (slot_outranks(i, c))
                break;
            swap_slots(i, c);
            i = c;
        end
    endfunction

    // Apply one item to the shadow heap and return the result it causes.
    function automatic heap_result_t apply_item(logic cmd, logic [9:0] k,
                                                logic [15:0] inc, logic [15:0] exc);
        heap_result_t r;
        r.popped_key = '0;
        if (cmd == CMD_POP) begin
            if (heap_size == 0) begin
                r.status = ST_EMPTY;
            end
            else begin
                r.popped_key = heap_key[0];
                key_in_heap[heap_key[0]] = 1'b0;
                heap_size = heap_size - 1;
                heap_key[0] = heap_key[heap_size];
                if (heap_size > 0)
                    key_slot[heap_key[0]] = '0;
                descend();
                r.status = ST_POPPED;
            end
        end
        else if (!key_in_heap[k]) begin
            key_in_heap[k] = 1'b1;
            key_incl[k] = inc;
            key_excl[k] = exc;
            key_slot[k] = 11'(heap_size);
            heap_key[heap_size] = k;
            heap_size = heap_size + 1;
            climb(k);
            r.status = ST_INSERTED;
        end
        else if (outranks(key_incl[k], key_excl[k], inc, exc)) begin
            r.status = ST_IGNORED;
        end
        else begin
            key_incl[k] = inc;
            key_excl[k] = exc;
            climb(k);
            r.status = ST_RAISED;
        end
        r.is_empty = (heap_size == 0);
        r.entry_count = 11'(heap_size);
        return r;
    endfunction

    assign outstanding = pending_results.size();

    // Predict on every accepted item, compare on every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        heap_result_t want;
        if (!rst_n) begin
            foreach (key_in_heap[i]) key_in_heap[i] = 1'b0;
            heap_size = 0;
            pending_results.delete();
            fail_count = 0;
            checked_count = 0;
            pops_seen = 0;
            raises_seen = 0;
        end
        else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $error("result with no item waiting: status %0d", status);
                    fail_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (want.status == ST_POPPED) pops_seen++;
                    if (want.status == ST_RAISED) raises_seen++;
                    if (popped_key !== want.popped_key) begin
                        $error("popped_key expected %0d actual %0d",
                               want.popped_key, popped_key);
                        fail_count++;
                    end
                    if (status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (is_empty !== want.is_empty) begin
                        $error("is_empty expected %0d actual %0d",
                               want.is_empty, is_empty);
                        fail_count++;
                    end
                    if (entry_count !== want.entry_count) begin
                        $error("entry_count expected %0d actual %0d",
                               want.entry_count, entry_count);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
                pending_results.push_back(apply_item(command, key, included, excluded));
        end
    end

endmodule

### verif/testbench.sv
// Top of the heap testbench: clock, reset, item stimulus, result draining
// and verdict. Depends on iph_pkg, indexed_priority_heap_top and heap_checker.
module testbench;
    import iph_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        command;
    logic [9:0]  key;
    logic [15:0] included;
    logic [15:0] excluded;
    logic        empty;
    logic        pop;
    logic [9:0]  popped_key;
    logic [2:0]  status;
    logic        is_empty;
    logic [10:0] entry_count;

    int fail_count;
    int outstanding;
    int checked_count;
    int pops_seen;
    int raises_seen;
    int items_sent;
    int cycle_count;
    bit quiet;
    bit hold_request;

    indexed_priority_heap_top u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .command(command),
        .key(key), .included(included), .excluded(excluded), .empty(empty),
        .pop(pop), .popped_key(popped_key), .status(status), .is_empty(is_empty),
        .entry_count(entry_count)
    );

    heap_checker u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .command(command),
        .key(key), .included(included), .excluded(excluded), .empty(empty),
        .pop(pop), .popped_key(popped_key), .status(status), .is_empty(is_empty),
        .entry_count(entry_count), .fail_count(fail_count),
        .outstanding(outstanding), .checked_count(checked_count),
        .pops_seen(pops_seen), .raises_seen(raises_seen)
    );

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Cycle limit covers the clearing pass plus slow pops and long stalls.
    initial
    begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 600000) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, one long hold on request, none when quiet.
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_request) begin
                pop = 1'b0;
                repeat (399) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop = 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge clk);
            end
            else begin
                pop = 1'b1;
            end
        end
    end

    // Offer one item, with an optional idle burst first; returns after acceptance.
    task automatic send_item(logic cmd, logic [9:0] k, logic [15:0] inc, logic [15:0] exc);
        if (!quiet && $urandom_range(0, 9) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        push = 1'b1;
        command = cmd;
        key = k;
        included = inc;
        excluded = exc;
        @(posedge clk);
        while (full) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Random item: narrow keys and priorities make raises and ties common.
    task automatic send_random(int pop_weight, bit narrow);
        logic [9:0]  k;
        logic [15:0] inc;
        logic [15:0] exc;
        k = narrow ? 10'($urandom_range(0, 47)) : 10'($urandom);
        inc = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 5)) : 16'($urandom);
        exc = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 5)) : 16'($urandom);
        if ($urandom_range(0, 99) < pop_weight)
            send_item(CMD_POP, 10'($urandom), 16'($urandom), 16'($urandom));
        else
            send_item(CMD_PUSH, k, inc, exc);
    endtask

    task automatic wait_drained();
        push = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        push = 1'b0;
        command = CMD_PUSH;
        key = '0;
        included = '0;
        excluded = '0;
        quiet = 1'b0;
        hold_request = 1'b0;
        items_sent = 0;
        @(posedge rst_n);
        @(negedge clk);

        // Directed: empty pop, extremes, equal and lesser priority, raises, ties.
        send_item(CMD_POP, 10'h3ff, 16'hffff, 16'hffff);
        send_item(CMD_PUSH, 10'd0, 16'hffff, 16'h0000);
        send_item(CMD_PUSH, 10'd1023, 16'h0000, 16'hffff);
        send_item(CMD_PUSH, 10'd1023, 16'h0000, 16'hffff);
        send_item(CMD_PUSH, 10'd0, 16'h0000, 16'h0000);
        send_item(CMD_PUSH, 10'd1023, 16'h0000, 16'hfffe);
        send_item(CMD_PUSH, 10'd1023, 16'hffff, 16'h0000);
        send_item(CMD_PUSH, 10'd5, 16'h8000, 16'h0010);
        send_item(CMD_PUSH, 10'd6, 16'h8000, 16'h0010);
        send_item(CMD_PUSH, 10'd7, 16'h8000, 16'h0008);
        send_item(CMD_PUSH, 10'd5, 16'h8000, 16'h0011);
        send_item(CMD_PUSH, 10'd682, 16'h5555, 16'haaaa);
        send_item(CMD_PUSH, 10'd341, 16'haaaa, 16'h5555);
        for (int i = 0; i < 9; i++)
            send_item(CMD_POP, 10'd0, 16'd0, 16'd0);
        send_item(CMD_POP, 10'd0, 16'd0, 16'd0);

        // Sender pause until all results are back.
        wait_drained();

        // Mixed traffic over few keys.
        for (int i = 0; i < 450; i++)
            send_random(40, 1'b1);
        wait_drained();

        // Fill deep while the receiver holds off so the input queue stalls.
        hold_request = 1'b1;
        for (int i = 0; i < 650; i++)
            send_random(8, 1'b0);

        // Drain-heavy traffic, last part without idling.
        for (int i = 0; i < 300; i++)
            send_random(65, i % 3 == 0);
        quiet = 1'b1;
        for (int i = 0; i < 150; i++)
            send_random(55, 1'b0);

        wait_drained();
        repeat (60) @(negedge clk);
        $display("Sent %0d items and checked %0d results, including %0d pops and %0d raises.",
                 items_sent, checked_count, pops_seen, raises_seen);
        if (fail_count == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
